// ===== hw/rtl/sample_average_encode_uart_tx_macros.svh =====
// Assertion helpers for the RTL file that carries checks.
// Every check is clocked on clk_i and is off while rst_ni is low.
`ifndef SAMPLE_AVERAGE_ENCODE_UART_TX_MACROS_SVH
`define SAMPLE_AVERAGE_ENCODE_UART_TX_MACROS_SVH

// The property must hold in the same cycle.
`define SAE_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// The property must hold in the cycle after the condition.
`define SAE_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/sae_pkg.sv =====
package sae_pkg;

  localparam int unsigned AVG_SAMPLES_DEF = 16;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned CHAN_W = 3;
  localparam int unsigned SUM_W = 12;
  localparam int unsigned STOP_W = 2;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned RECIP_SHIFT = 20;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [SAMPLE_W-1:0] NIBBLE_MASK = 8'h0F;
  localparam logic [SAMPLE_W-1:0] HIGH_FLAG = 8'h80;
  localparam logic [SAMPLE_W-1:0] AVG_MAX = 8'hFF;
  localparam logic [IDX_W-1:0] DATA_BITS = 4'd8;

  typedef struct packed {
    logic done;
    logic [SAMPLE_W-1:0] byte_lo;
    logic [SAMPLE_W-1:0] byte_hi;
  } group_t;

  typedef struct packed {
    logic tx_line;
    logic busy;
    logic overrun;
  } tx_status_t;

endpackage

// ===== hw/rtl/sae_if.sv =====
interface sae_in_if import sae_pkg::*; ();
  logic valid;
  logic ready;
  logic mode;
  logic [CHAN_W-1:0] channel;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, mode, channel, sample, input ready);
  modport sink (input valid, mode, channel, sample, output ready);
endinterface

interface sae_out_if;
  logic valid;
  logic ready;
  logic tx_line;
  logic busy_res;
  logic group_done;
  logic overrun;

  modport source (output valid, tx_line, busy_res, group_done, overrun, input ready);
  modport sink (input valid, tx_line, busy_res, group_done, overrun, output ready);
endinterface

interface sae_cfg_if import sae_pkg::*; ();
  logic valid;
  logic ready;
  logic [STOP_W-1:0] stop_bits;

  modport source (output valid, stop_bits, input ready);
  modport sink (input valid, stop_bits, output ready);
endinterface

// ===== hw/rtl/sae_avg.sv =====
module sae_avg import sae_pkg::*; #(
  parameter int unsigned AvgSamples = AVG_SAMPLES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sample_en_i,
  input  logic [CHAN_W-1:0]   channel_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output group_t              group_o
);

  localparam int unsigned CntW = (AvgSamples > 1) ? $clog2(AvgSamples) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(AvgSamples - 1);
  localparam int unsigned RecipW = RECIP_SHIFT + 1;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RECIP_SHIFT) + AvgSamples - 1) / AvgSamples);
  localparam int unsigned ProdW = SUM_W + RecipW;

  logic [SUM_W-1:0] sum_q, sum_d, sum_new;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CHAN_W-1:0] chan_q, chan_d, chan_grp;
  logic [ProdW-1:0] prod;
  logic [ProdW-RECIP_SHIFT-1:0] quot;
  logic [SAMPLE_W-1:0] avg;
  logic last;

  assign sum_new = sum_q + SUM_W'(sample_i);
  assign last = (cnt_q == CntLast);
  assign chan_grp = (cnt_q == '0) ? channel_i : chan_q;

  // The group mean is taken by a reciprocal multiply, exact for every 12-bit sum.
  assign prod = ProdW'(sum_new) * ProdW'(Recip);
  assign quot = prod[ProdW-1:RECIP_SHIFT];
  assign avg = (quot > (ProdW-RECIP_SHIFT)'(AVG_MAX)) ? AVG_MAX : quot[SAMPLE_W-1:0];

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    chan_d = chan_q;
    if (sample_en_i) begin
      chan_d = chan_grp;
      if (last) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_new;
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      chan_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      chan_q <= chan_d;
    end
  end

  assign group_o.done = sample_en_i && last;
  assign group_o.byte_lo = (avg & NIBBLE_MASK) | {1'b0, chan_grp, 4'b0000};
  assign group_o.byte_hi = (avg >> 4) | HIGH_FLAG | {1'b0, chan_grp, 4'b0000};

endmodule

// ===== hw/rtl/sae_tx.sv =====
module sae_tx import sae_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_en_i,
  input  group_t            group_i,
  input  logic [STOP_W-1:0] stop_bits_i,
  output tx_status_t        status_o
);

  logic sending_q, sending_d;
  logic [IDX_W-1:0] idx_q, idx_d, last_idx, stop_cnt;
  logic [1:0] cnt_q, cnt_d;
  logic [SAMPLE_W-1:0] byte0_q, byte0_d, byte1_q, byte1_d;
  logic [2:0] bit_sel;
  logic busy_cur;
  logic line_lvl;

  always_comb begin
    unique case (stop_bits_i)
      2'd0, 2'd1: stop_cnt = 4'd1;
      default:    stop_cnt = 4'd2;
    endcase
  end

  assign last_idx = DATA_BITS + stop_cnt;
  assign busy_cur = sending_q || (cnt_q != 2'd0);

  always_comb begin
    sending_d = sending_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    byte0_d = byte0_q;
    byte1_d = byte1_q;
    if (group_i.done && !busy_cur) begin
      byte0_d = group_i.byte_lo;
      byte1_d = group_i.byte_hi;
      cnt_d = 2'd2;
    end
    if (tick_en_i) begin
      priority if (!sending_q) begin
        sending_d = (cnt_q != 2'd0);
        idx_d = '0;
      end else if (idx_q >= last_idx) begin
        byte0_d = byte1_q;
        cnt_d = (cnt_q != 2'd0) ? cnt_q - 2'd1 : 2'd0;
        sending_d = (cnt_q > 2'd1);
        idx_d = '0;
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      sending_q <= sending_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte0_q <= byte0_d;
    byte1_q <= byte1_d;
  end

  assign bit_sel = 3'(idx_d - IDX_W'(1));

  always_comb begin
    priority if (!sending_d) begin
      line_lvl = 1'b1;
    end else if (idx_d == '0) begin
      line_lvl = 1'b0;
    end else if (idx_d <= DATA_BITS) begin
      line_lvl = byte0_d[bit_sel];
    end else begin
      line_lvl = 1'b1;
    end
  end

  assign status_o.tx_line = line_lvl;
  assign status_o.busy = sending_d || (cnt_d != 2'd0);
  assign status_o.overrun = group_i.done && busy_cur;

endmodule

// ===== hw/rtl/sample_average_encode_uart_tx.sv =====
// Sample averager with an 8N1-style serial transmitter. Each input beat is either a
// converter sample (mode 0) or one serial bit time (mode 1) and yields exactly one
// result beat with the line level, the busy flag, and the group-done and overrun
// flags after that beat. Beats pass through an input register and a result register
// with all work in between, so one beat is taken every clock cycle and each beat's result is
// registered from the input register into the result register, paced only by the result side's ready.
// A group that completes while bytes are still queued or sending is dropped and
// flagged as an overrun. The stop bit count may be written only while the block is idle.
`include "sample_average_encode_uart_tx_macros.svh"

module sample_average_encode_uart_tx import sae_pkg::*; #(
  parameter int unsigned AvgSamples = AVG_SAMPLES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  sae_cfg_if.sink   cfg_i,
  sae_in_if.sink    in_i,
  sae_out_if.source out_o
);

  logic [STOP_W-1:0] stop_bits_q;
  logic s1_valid_q, s1_valid_d;
  logic s1_mode_q;
  logic [CHAN_W-1:0] s1_channel_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic out_valid_q, out_valid_d;
  logic in_fire, advance;
  group_t group;
  tx_status_t status;
  logic res_line_q, res_busy_q, res_done_q, res_ovr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_bits_q <= STOP_W'(1);
    end else if (cfg_i.valid) begin
      stop_bits_q <= cfg_i.stop_bits;
    end
  end

  assign advance = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire = in_i.valid && in_i.ready;

  assign s1_valid_d = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q <= in_i.mode;
      s1_channel_q <= in_i.channel;
      s1_sample_q <= in_i.sample;
    end
  end

  sae_avg #(
    .AvgSamples(AvgSamples)
  ) u_avg (
    .clk_i,
    .rst_ni,
    .sample_en_i(advance && (s1_mode_q == MODE_SAMPLE)),
    .channel_i  (s1_channel_q),
    .sample_i   (s1_sample_q),
    .group_o    (group)
  );

  sae_tx u_tx (
    .clk_i,
    .rst_ni,
    .tick_en_i  (advance && (s1_mode_q == MODE_TICK)),
    .group_i    (group),
    .stop_bits_i(stop_bits_q),
    .status_o   (status)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_line_q <= status.tx_line;
      res_busy_q <= status.busy;
      res_done_q <= group.done;
      res_ovr_q <= status.overrun;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.tx_line = res_line_q;
  assign out_o.busy_res = res_busy_q;
  assign out_o.group_done = res_done_q;
  assign out_o.overrun = res_ovr_q;

  `SAE_ASSERT_SAME(a_ovr_needs_done, out_valid_q && res_ovr_q, res_done_q, "overrun without group done")
  `SAE_ASSERT_SAME(a_low_needs_busy, out_valid_q && !res_line_q, res_busy_q, "line low while not busy")
  `SAE_ASSERT_NEXT(a_accept_loads, in_fire, s1_valid_q, "accepted beat not held in input stage")
  `SAE_ASSERT_NEXT(a_advance_shows, advance, out_valid_q, "advanced beat not shown on result side")

endmodule

// ===== tb/sample_average_encode_uart_tx_tb.sv =====
`timescale 1ns / 1ps

module sample_average_encode_uart_tx_tb;
  import sae_pkg::*;

  typedef struct packed {
    logic tx_line;
    logic busy;
    logic group_done;
    logic overrun;
  } line_result_t;

  class line_scoreboard;
    logic [STOP_W-1:0]   stop_sel;
    logic [SUM_W-1:0]    sum_acc;
    int unsigned         taken;
    logic [CHAN_W-1:0]   grp_chan;
    logic [SAMPLE_W-1:0] byte_q [2];
    int unsigned         queued;
    int unsigned         bit_pos;
    bit                  sending;
    line_result_t        line_want_q [$];
    int unsigned         beats_seen;
    int unsigned         errors;

    function new();
      stop_sel = 2'd1;
      sum_acc = '0;
      taken = 0;
      grp_chan = '0;
      byte_q[0] = '0;
      byte_q[1] = '0;
      queued = 0;
      bit_pos = 0;
      sending = 1'b0;
      beats_seen = 0;
      errors = 0;
    endfunction

    function int unsigned stop_len();
      if (stop_sel == 2'd0) return 1;
      if (stop_sel == 2'd3) return 2;
      return int'(stop_sel);
    endfunction

    function bit is_busy();
      return sending || (queued != 0);
    endfunction

    function logic line_level();
      if (!sending) return 1'b1;
      if (bit_pos == 0) return 1'b0;
      if (bit_pos <= DATA_BITS) return byte_q[0][bit_pos-1];
      return 1'b1;
    endfunction

    function void load_next();
      sending = (queued != 0);
      bit_pos = 0;
    endfunction

    function void bit_time();
      if (!sending) begin
        load_next();
        return;
      end
      bit_pos++;
      if (bit_pos > DATA_BITS + stop_len()) begin
        byte_q[0] = byte_q[1];
        if (queued != 0) queued--;
        load_next();
      end
    endfunction

    function void note_beat(logic mode, logic [CHAN_W-1:0] chan, logic [SAMPLE_W-1:0] samp);
      line_result_t        want;
      logic [SUM_W-1:0]    quot;
      logic [SAMPLE_W-1:0] avg;
      logic [SAMPLE_W-1:0] chan_bits;
      want = '0;
      if (mode == MODE_SAMPLE) begin
        if (taken == 0) grp_chan = chan;
        sum_acc = sum_acc + SUM_W'(samp);
        taken++;
        if (taken >= AVG_SAMPLES_DEF) begin
          quot = SUM_W'(sum_acc / AVG_SAMPLES_DEF);
          avg = (quot > AVG_MAX) ? AVG_MAX : quot[SAMPLE_W-1:0];
          chan_bits = {1'b0, grp_chan, 4'b0000};
          want.group_done = 1'b1;
          if (is_busy()) begin
            want.overrun = 1'b1;
          end else begin
            byte_q[0] = (avg & NIBBLE_MASK) | chan_bits;
            byte_q[1] = (avg >> 4) | HIGH_FLAG | chan_bits;
            queued = 2;
          end
          sum_acc = '0;
          taken = 0;
        end
      end else begin
        bit_time();
      end
      want.tx_line = line_level();
      want.busy = is_busy();
      line_want_q.push_back(want);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("MISMATCH %0d: %s", errors, what);
    endtask

    task check_beat(logic tx, logic busy, logic done, logic ovr);
      line_result_t want;
      beats_seen++;
      if (line_want_q.size() == 0) begin
        report($sformatf("result beat %0d arrived with nothing outstanding", beats_seen));
        return;
      end
      want = line_want_q.pop_front();
      if (tx !== want.tx_line)
        report($sformatf("beat %0d tx_line %b, wanted %b", beats_seen, tx, want.tx_line));
      if (busy !== want.busy)
        report($sformatf("beat %0d busy_res %b, wanted %b", beats_seen, busy, want.busy));
      if (done !== want.group_done)
        report($sformatf("beat %0d group_done %b, wanted %b", beats_seen, done,
                         want.group_done));
      if (ovr !== want.overrun)
        report($sformatf("beat %0d overrun %b, wanted %b", beats_seen, ovr, want.overrun));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   in_calm;

  line_scoreboard sb;

  sae_in_if  in_if ();
  sae_out_if out_if ();
  sae_cfg_if cfg_if ();

  sample_average_encode_uart_tx u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(logic mode, logic [CHAN_W-1:0] chan, logic [SAMPLE_W-1:0] samp);
    int unsigned gap;
    if ($urandom_range(0, 24) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= mode;
    in_if.channel <= chan;
    in_if.sample <= samp;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_beat(mode, chan, samp);
  endtask

  task automatic write_stop_bits(logic [STOP_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.stop_bits <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.stop_sel = value;
  endtask

  task automatic run_random(int unsigned count, int unsigned tick_pct);
    logic                mode;
    logic [SAMPLE_W-1:0] samp;
    int unsigned         pick;
    for (int unsigned i = 0; i < count; i++) begin
      mode = ($urandom_range(0, 99) < tick_pct) ? MODE_TICK : MODE_SAMPLE;
      pick = $urandom_range(0, 9);
      if (pick == 0) samp = 8'h00;
      else if (pick == 1) samp = 8'hFF;
      else samp = SAMPLE_W'($urandom_range(0, 255));
      send_item(mode, CHAN_W'($urandom_range(0, 7)), samp);
    end
  endtask

  // Sends bit times until the transmitter is idle, then waits for the last results.
  task automatic finish_phase();
    while (sb.is_busy())
      send_item(MODE_TICK, CHAN_W'($urandom_range(0, 7)), SAMPLE_W'($urandom_range(0, 255)));
    in_if.valid <= 1'b0;
    while (sb.line_want_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned gap;
    bit          calm;
    calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 24) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_beat(out_if.tx_line, out_if.busy_res, out_if.group_done, out_if.overrun);
    end
  end

  initial begin : stimulus
    sb = new();
    in_calm = 1'b0;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.mode <= MODE_SAMPLE;
    in_if.channel <= '0;
    in_if.sample <= '0;
    out_if.ready <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.stop_bits <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A full-scale group on the top channel, sent with the reset stop bit count.
    send_item(MODE_TICK, 3'd0, 8'h00);
    for (int i = 0; i < 16; i++) begin
      send_item(MODE_SAMPLE, (i == 0) ? 3'd7 : 3'(i), 8'hFF);
    end
    repeat (8) send_item(MODE_TICK, 3'd7, 8'hFF);
    finish_phase();

    write_stop_bits(2'd2);
    run_random(105, 50);
    finish_phase();
    write_stop_bits(2'd0);
    run_random(105, 40);
    finish_phase();
    write_stop_bits(2'd3);
    run_random(105, 65);
    finish_phase();
    write_stop_bits(2'd1);
    run_random(105, 55);
    finish_phase();

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.line_want_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sae_pkg.sv
hw/rtl/sae_if.sv
hw/rtl/sae_avg.sv
hw/rtl/sae_tx.sv
hw/rtl/sample_average_encode_uart_tx.sv
tb/sample_average_encode_uart_tx_tb.sv
